/* src/pbrle_pkg.sv */
package pbrle_pkg;

	localparam int CODE_W      = 8;
	localparam int COUNT_W     = 8;
	localparam int BYTE_FIELDS = 4;
	localparam int OUT_LANES   = 4;
	// lanes actually used: OUT_LANES clamped to the byte fields that exist
	localparam int LANES = (OUT_LANES < 1) ? 1 :
		((OUT_LANES > BYTE_FIELDS) ? BYTE_FIELDS : OUT_LANES);
	localparam int BYTE_COUNT_W = 3;
	localparam int WORD_BITS    = BYTE_FIELDS * CODE_W + BYTE_COUNT_W;
	localparam int TDATA_W      = ((WORD_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CODE_W-1:0] LITERAL_MAX = 8'd127;
	localparam logic [CODE_W-1:0] NOOP_CODE   = 8'd128;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LITERAL = 2'd1,
		PH_RUN     = 2'd2,
		PH_SPARE   = 2'd3
	} phase_t;

	// one request from front to back: emit value len times (len 1..128)
	typedef struct packed {
		logic [CODE_W-1:0]  value;
		logic [COUNT_W-1:0] len;
	} run_req_t;

endpackage

/* src/pbrle_front.sv */
module pbrle_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [pbrle_pkg::CODE_W-1:0] in_code,
	output logic                   req_valid,
	input  logic                   req_ready,
	output pbrle_pkg::run_req_t    req
);

	pbrle_pkg::phase_t              phase_q, phase_d;
	logic [pbrle_pkg::COUNT_W-1:0]  rem_q, rem_d;
	logic [pbrle_pkg::COUNT_W-1:0]  cnt;
	logic [pbrle_pkg::COUNT_W:0]    run_len;
	logic                           is_header;
	logic                           take;

	assign cnt       = (rem_q == '0) ? pbrle_pkg::COUNT_W'(1) : rem_q;
	assign is_header = (phase_q != pbrle_pkg::PH_LITERAL) && (phase_q != pbrle_pkg::PH_RUN);
	// 257 - code gives the run length 2..128 for codes 129..255
	assign run_len   = (pbrle_pkg::COUNT_W+1)'(257) - {1'b0, in_code};
	assign take      = in_valid && in_ready;

	// next state
	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		if (take) begin
			unique case (phase_q)
				pbrle_pkg::PH_LITERAL: begin
					rem_d   = cnt - pbrle_pkg::COUNT_W'(1);
					phase_d = (rem_d == '0) ? pbrle_pkg::PH_HEADER : pbrle_pkg::PH_LITERAL;
				end
				pbrle_pkg::PH_RUN: begin
					rem_d   = '0;
					phase_d = pbrle_pkg::PH_HEADER;
				end
				default: begin
					if (in_code <= pbrle_pkg::LITERAL_MAX) begin
						rem_d   = in_code + pbrle_pkg::COUNT_W'(1);
						phase_d = pbrle_pkg::PH_LITERAL;
					end else if (in_code == pbrle_pkg::NOOP_CODE) begin
						rem_d   = '0;
						phase_d = pbrle_pkg::PH_HEADER;
					end else begin
						rem_d   = run_len[pbrle_pkg::COUNT_W-1:0];
						phase_d = pbrle_pkg::PH_RUN;
					end
				end
			endcase
		end
	end

	// outputs: headers never need queue room
	always_comb begin
		in_ready  = is_header || req_ready;
		req_valid = in_valid && !is_header;
		req.value = in_code;
		unique case (phase_q)
			pbrle_pkg::PH_RUN: req.len = cnt;
			default:           req.len = pbrle_pkg::COUNT_W'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbrle_pkg::PH_HEADER;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
		end
	end

endmodule

/* src/pbrle_fifo.sv */
module pbrle_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pbrle_pkg::run_req_t push_data,
	output logic                not_full,
	input  logic                pop,
	output logic                not_empty,
	output pbrle_pkg::run_req_t head
);

	pbrle_pkg::run_req_t             mem_q [pbrle_pkg::QUEUE_DEPTH];
	logic [pbrle_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [pbrle_pkg::QCNT_W-1:0]    count_q;
	logic                            do_push, do_pop;

	assign not_full  = (count_q != pbrle_pkg::QCNT_W'(pbrle_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + pbrle_pkg::QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + pbrle_pkg::QPTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + pbrle_pkg::QCNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - pbrle_pkg::QCNT_W'(1);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pbrle_pkg::QCNT_W'(pbrle_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != pbrle_pkg::QCNT_W'(pbrle_pkg::QUEUE_DEPTH))
		|-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");
	a_no_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		not_empty |-> (head.len != '0))
		else $error("queued request with zero length");

endmodule

/* src/pbrle_back.sv */
module pbrle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  pbrle_pkg::run_req_t req,
	output logic                req_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [pbrle_pkg::TDATA_W-1:0] out_data,
	output logic                out_last
);

	logic                                busy_q;
	logic [pbrle_pkg::COUNT_W-1:0]       rem_q;
	logic [pbrle_pkg::CODE_W-1:0]        val_q;
	logic                                valid_q;
	logic [pbrle_pkg::TDATA_W-1:0]       data_q;
	logic                                last_q;

	logic                                src_valid, adv;
	logic [pbrle_pkg::COUNT_W-1:0]       cur_rem, rem_next;
	logic [pbrle_pkg::CODE_W-1:0]        cur_val;
	logic [pbrle_pkg::BYTE_COUNT_W-1:0]  n;
	logic [pbrle_pkg::BYTE_FIELDS*pbrle_pkg::CODE_W-1:0] bytes;

	assign src_valid = busy_q || req_valid;
	assign cur_rem   = busy_q ? rem_q : req.len;
	assign cur_val   = busy_q ? val_q : req.value;
	assign adv       = src_valid && (!valid_q || out_ready);
	assign req_pop   = adv && !busy_q;
	assign n         = (cur_rem < pbrle_pkg::COUNT_W'(pbrle_pkg::LANES)) ?
		cur_rem[pbrle_pkg::BYTE_COUNT_W-1:0] : pbrle_pkg::BYTE_COUNT_W'(pbrle_pkg::LANES);
	assign rem_next  = cur_rem - {{(pbrle_pkg::COUNT_W-pbrle_pkg::BYTE_COUNT_W){1'b0}}, n};

	always_comb begin
		for (int j = 0; j < pbrle_pkg::BYTE_FIELDS; j++) begin
			bytes[j*pbrle_pkg::CODE_W +: pbrle_pkg::CODE_W] =
				(pbrle_pkg::BYTE_COUNT_W'(j) < n) ? cur_val : '0;
		end
	end

	// output word register, and working registers for a run that spans several words
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q  <= rem_next;
			data_q <= pbrle_pkg::TDATA_W'({n, bytes});
			last_q <= (rem_next == '0);
			if (!busy_q) val_q <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				busy_q  <= (rem_next != '0);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0))
		else $error("busy with nothing left to emit");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (data_q[pbrle_pkg::BYTE_FIELDS*pbrle_pkg::CODE_W +: pbrle_pkg::BYTE_COUNT_W]
			!= '0 &&
			data_q[pbrle_pkg::BYTE_FIELDS*pbrle_pkg::CODE_W +: pbrle_pkg::BYTE_COUNT_W]
			<= pbrle_pkg::BYTE_COUNT_W'(pbrle_pkg::LANES)))
		else $error("word byte count out of range");
	a_busy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rem_next != '0) |=> (busy_q && !last_q))
		else $error("run ended early");
	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req_pop)
		else $error("request taken while a run is in progress");

endmodule

/* src/packbits_rle_decoder_unit.sv */
// PackBits decoder: takes one compressed byte per request on s_axis and gives decoded
// words on m_axis. A header 0..127 announces header+1 literal bytes, each of which comes
// out as its own word with byte_count 1; a header 129..255 announces a run of 257-header
// bytes of the next byte's value, which comes out packed four bytes to a word with the
// final word full or partly filled; header 128 is skipped. tlast marks the final word
// caused by one input byte (every literal word, and the closing word of each run). Rate:
// the front end takes one byte per cycle as long as its four-entry request queue has
// room, and headers need no room at all. The back end emits one word per cycle while the
// receiver is ready, so a literal yields one word and a run of L bytes yields ceil(L/4)
// words (1 to 32); that word-per-cycle emitter sets the sustained throughput on run-heavy
// streams. A literal or run value passes the request queue, then the output register;
// that register lets a new word be built in the cycle the previous one is taken.
module packbits_rle_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [pbrle_pkg::CODE_W-1:0]      s_axis_tdata,  // [7:0] code_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3, [34:32] byte_count,
	// upper bits zero
	output logic [pbrle_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic                              m_axis_tlast   // last_of_input
);

	// request path from front to queue
	logic                 fq_valid;
	logic                 fq_ready;
	pbrle_pkg::run_req_t  fq_req;

	// queue head toward the back end
	logic                 qb_valid;
	logic                 qb_pop;
	pbrle_pkg::run_req_t  qb_req;

	// classify bytes: headers update the phase, literals and run values become requests
	pbrle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_code   (s_axis_tdata),
		.req_valid (fq_valid),
		.req_ready (fq_ready),
		.req       (fq_req)
	);

	// hold pending requests so either side may stall on its own
	pbrle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_valid),
		.push_data (fq_req),
		.not_full  (fq_ready),
		.pop       (qb_pop),
		.not_empty (qb_valid),
		.head      (qb_req)
	);

	// expand each request into one or more packed words
	pbrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (qb_valid),
		.req       (qb_req),
		.req_pop   (qb_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* tb/packbits_word_checker.sv */
`timescale 1ns / 100ps

module packbits_word_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [pbrle_pkg::CODE_W-1:0]  s_axis_tdata,   // [7:0] code_byte
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3, [34:32] byte_count
	input  logic [pbrle_pkg::TDATA_W-1:0] m_axis_tdata,
	input  logic                          m_axis_tlast,   // last_of_input
	output int                            fail_count,
	output int                            words_due
);

	import pbrle_pkg::*;

	typedef struct packed {
		logic [BYTE_FIELDS-1:0][CODE_W-1:0] lanes;
		logic [BYTE_COUNT_W-1:0]            n_bytes;
		logic                               last;
	} dec_word_t;

	phase_t             dec_phase;
	logic [COUNT_W-1:0] dec_left;
	dec_word_t          due_q[$];
	int                 mismatches = 0;

	task automatic push_word(input logic [CODE_W-1:0] value, input int n, input logic fin);
		dec_word_t w;
		for (int j = 0; j < BYTE_FIELDS; j++)
			w.lanes[j] = (j < n) ? value : '0;
		w.n_bytes = n[BYTE_COUNT_W-1:0];
		w.last = fin;
		due_q.push_back(w);
	endtask

	// advance the decoder by one code byte and queue the words it yields
	task automatic decode_code_byte(input logic [CODE_W-1:0] code);
		int left;
		int n;
		left = (dec_left == '0) ? 1 : int'(dec_left);
		case (dec_phase)
		PH_LITERAL: begin
			push_word(code, 1, 1'b1);
			left--;
			dec_left = left[COUNT_W-1:0];
			dec_phase = (left == 0) ? PH_HEADER : PH_LITERAL;
		end
		PH_RUN: begin
			while (left > 0) begin
				n = (left < LANES) ? left : LANES;
				left -= n;
				push_word(code, n, left == 0);
			end
			dec_left = '0;
			dec_phase = PH_HEADER;
		end
		default: begin
			if (code <= LITERAL_MAX) begin
				dec_left = code + 8'd1;
				dec_phase = PH_LITERAL;
			end else if (code == NOOP_CODE) begin
				dec_left = '0;
				dec_phase = PH_HEADER;
			end else begin
				dec_left = 8'(9'd257 - {1'b0, code});
				dec_phase = PH_RUN;
			end
		end
		endcase
	endtask

	task automatic check_word();
		dec_word_t got;
		dec_word_t want;
		logic [TDATA_W-WORD_BITS-1:0] pad;
		got.lanes = m_axis_tdata[BYTE_FIELDS*CODE_W-1:0];
		got.n_bytes = m_axis_tdata[WORD_BITS-1:BYTE_FIELDS*CODE_W];
		got.last = m_axis_tlast;
		pad = m_axis_tdata[TDATA_W-1:WORD_BITS];
		if (due_q.size() == 0) begin
			$display("%0t: word with none due: expected nothing, got tdata %h tlast %b",
				$time, m_axis_tdata, m_axis_tlast);
			mismatches++;
		end else begin
			want = due_q.pop_front();
			for (int j = 0; j < BYTE_FIELDS; j++)
				if (got.lanes[j] !== want.lanes[j]) begin
					$display("%0t: byte_%0d expected %h got %h",
						$time, j, want.lanes[j], got.lanes[j]);
					mismatches++;
				end
			if (got.n_bytes !== want.n_bytes) begin
				$display("%0t: byte_count expected %0d got %0d",
					$time, want.n_bytes, got.n_bytes);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_of_input expected %b got %b", $time, want.last, got.last);
				mismatches++;
			end
			if (pad !== '0) begin
				$display("%0t: tdata padding expected 0 got %h", $time, pad);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_phase = PH_HEADER;
			dec_left = '0;
			due_q.delete();
			words_due <= 0;
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_code_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_word();
			words_due <= due_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* tb/tb_packbits_rle_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_packbits_rle_decoder_unit;

	import pbrle_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [CODE_W-1:0]   s_axis_tdata;    // [7:0] code_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3, [34:32] byte_count
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic                m_axis_tlast;    // last_of_input

	int fail_count;
	int words_due;

	// quiet: no idling on either side (closing part of the run)
	// burst_tx: sender offers back to back while the receiver is held off
	// hold_out: ask the receiver process for one long hold-off
	bit quiet    = 1'b0;
	bit burst_tx = 1'b0;
	bit hold_out = 1'b0;
	int codes_sent = 0;

	localparam int RANDOM_CODES = 360;
	localparam int QUIET_CODES  = 60;
	localparam int LONG_HOLD    = 300;

	packbits_rle_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	packbits_word_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.words_due     (words_due)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one code byte as a request. Entered and left at a falling edge; the
	// handshake is judged at the rising edge. A gap, when taken, lowers tvalid
	// at the current falling edge and raises it again at a later one.
	task automatic send_code(input logic [CODE_W-1:0] code);
		int gap;
		if (!quiet && !burst_tx && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		codes_sent++;
		@(negedge clk);
	endtask

	// hold until every queued word has drained, then return at a falling edge
	task automatic drain_words();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One well-formed packet with random content: mostly short literal
	// packets and short runs, now and then the longest of each, and a
	// sprinkling of no-op headers.
	task automatic send_packet();
		int pick;
		int n;
		logic [CODE_W-1:0] hdr;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			send_code(NOOP_CODE);
		end else if (pick < 10) begin
			if ($urandom_range(0, 19) == 0)
				n = $urandom_range(0, 1) ? int'(LITERAL_MAX) : $urandom_range(8, 126);
			else
				n = $urandom_range(0, 7);
			send_code(n[CODE_W-1:0]);
			repeat (n + 1)
				send_code(8'($urandom_range(0, 255)));
		end else begin
			// run header: 255 down to 241 gives lengths 2..16, 129 the longest
			if ($urandom_range(0, 11) == 0)
				hdr = $urandom_range(0, 1) ? 8'd129 : 8'($urandom_range(129, 240));
			else
				hdr = 8'($urandom_range(241, 255));
			send_code(hdr);
			send_code(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: alternate ready stretches with stall bursts, take one long
	// hold-off when asked, and stay ready once the run goes quiet.
	initial begin
		int span;
		logic level;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_out) begin
				level = 1'b0;
				span = LONG_HOLD;
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				level = 1'b0;
				span = $urandom_range(1, 15);
			end else begin
				level = 1'b1;
				span = $urandom_range(1, 30);
			end
			m_axis_tready <= level;
			repeat (span) @(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single literal of value zero
		send_code(8'd0);
		send_code(8'h00);
		// two literals, the second equal to the no-op code: it stays data
		send_code(8'd1);
		send_code(8'hFF);
		send_code(NOOP_CODE);
		// no-op header on its own
		send_code(NOOP_CODE);
		// shortest run, one partial word
		send_code(8'd255);
		send_code(8'hFF);
		// longest run: 128 bytes in 32 full words
		send_code(8'd129);
		send_code(8'hA5);
		// runs of 3, 4 and 5: partial, exactly full, full plus one
		send_code(8'd254);
		send_code(NOOP_CODE);
		send_code(8'd253);
		send_code(8'h00);
		send_code(8'd252);
		send_code(LITERAL_MAX);
		// back to back no-ops
		send_code(NOOP_CODE);
		send_code(NOOP_CODE);
		// three literals that look like headers
		send_code(8'd2);
		send_code(8'h81);
		send_code(LITERAL_MAX);
		send_code(8'h00);

		// pause the sender until every word of the opening part is out
		drain_words();

		// Hold the receiver off for a long stretch while run-heavy requests
		// keep coming, so the request queue fills and s_axis_tready drops.
		// Start sending only once the hold-off has begun.
		hold_out = 1'b1;
		wait (hold_out == 1'b0);
		burst_tx = 1'b1;
		repeat (10) begin
			send_code(8'($urandom_range(241, 255)));
			send_code(8'($urandom_range(0, 255)));
			send_code(8'd0);
			send_code(8'($urandom_range(0, 255)));
		end
		burst_tx = 1'b0;

		// random packets, idling on both sides
		while (codes_sent < RANDOM_CODES - QUIET_CODES)
			send_packet();
		// closing stretch with no idling at all
		quiet = 1'b1;
		while (codes_sent < RANDOM_CODES)
			send_packet();

		drain_words();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("packbits_rle_decoder_unit: match");
		else
			$display("packbits_rle_decoder_unit: mismatch");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("packbits_rle_decoder_unit: mismatch");
		$finish;
	end

endmodule
